[hw/rtl/lfpd_pkg.sv]
// lfpd_pkg: shared widths, reset values, register indexes and command types
// for the line follower pid motor drive block
// no dependencies
package lfpd_pkg;

   localparam int SENSOR_COUNT_DEF = 7;
   localparam int SENSOR_IN_W      = 7;

   localparam int GAIN_W     = 20;
   localparam int CFG_W      = 12;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   localparam int SUM_W   = 13;
   localparam int ACC_W   = 36;
   localparam int P_FRAC  = 8;
   localparam int T_FRAC  = 10;
   localparam int CORR_W  = ACC_W - P_FRAC;
   localparam int OPA_W   = GAIN_W + 1;
   localparam int OPB_W   = 30;
   localparam int PROD_W  = OPA_W + OPB_W;
   localparam int CMD_W   = 32;
   localparam int WHEEL_W = 14;
   localparam int PWM_W   = 2 * WHEEL_W;
   localparam int LERR_W  = 4;

   localparam logic [GAIN_W-1:0] GAIN_P_RST         = 20'd38400;
   localparam logic [GAIN_W-1:0] GAIN_I_RST         = 20'd13;
   localparam logic [GAIN_W-1:0] GAIN_D_RST         = 20'd256000;
   localparam logic [CFG_W-1:0]  RIGHT_TRIM_RST     = 12'd1201;
   localparam logic [CFG_W-1:0]  DEAD_BAND_RST      = 12'd1950;
   localparam logic [CFG_W-1:0]  BASE_SPEED_RST     = 12'd250;
   localparam logic [CFG_W-1:0]  PWM_LIMIT_RST      = 12'd3125;
   localparam logic [CFG_W-1:0]  INTEGRAL_LIMIT_RST = 12'd500;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_P         = 3'd0,
      CSR_GAIN_I         = 3'd1,
      CSR_GAIN_D         = 3'd2,
      CSR_RIGHT_TRIM     = 3'd3,
      CSR_DEAD_BAND      = 3'd4,
      CSR_BASE_SPEED     = 3'd5,
      CSR_PWM_LIMIT      = 3'd6,
      CSR_INTEGRAL_LIMIT = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0] gain_p;
      logic [GAIN_W-1:0] gain_i;
      logic [GAIN_W-1:0] gain_d;
      logic [CFG_W-1:0]  right_trim;
      logic [CFG_W-1:0]  dead_band;
      logic [CFG_W-1:0]  base_speed;
      logic [CFG_W-1:0]  pwm_limit;
      logic [CFG_W-1:0]  integral_limit;
   } cfg_type;

   typedef enum logic [1:0] {
      MSEL_P,
      MSEL_I,
      MSEL_D,
      MSEL_T
   } mul_sel_type;

   typedef struct packed {
      logic        capture;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        acc_clr;
      logic        acc_add;
      logic        div_en;
      logic        lr_en;
      logic        tdiv_en;
      logic        pack_en;
   } dp_cmd_type;

   // dead band away from zero, symmetric saturation, then enable/reverse/speed
   function automatic logic [WHEEL_W-1:0] pack_wheel(
      input logic signed [CMD_W-1:0] cmd,
      input logic [CFG_W-1:0]        dead,
      input logic [CFG_W-1:0]        lim
   );
      logic signed [CMD_W:0] c;
      logic signed [CMD_W:0] l;
      logic signed [CMD_W:0] d;
      logic signed [CMD_W:0] mag;
      logic                  neg;
      l = $signed({{(CMD_W-CFG_W+1){1'b0}}, lim});
      d = $signed({{(CMD_W-CFG_W+1){1'b0}}, dead});
      if (cmd > 0) begin
         c = $signed({cmd[CMD_W-1], cmd}) + d;
      end else if (cmd < 0) begin
         c = $signed({cmd[CMD_W-1], cmd}) - d;
      end else begin
         c = '0;
      end
      if (c > l) begin
         c = l;
      end else if (c < -l) begin
         c = -l;
      end
      neg = c[CMD_W];
      mag = neg ? -c : c;
      return {1'b1, neg, mag[CFG_W-1:0]};
   endfunction

endpackage

[hw/rtl/lfpd_regs.sv]
// lfpd_regs: configuration register file written through the csr channel
// depends on lfpd_pkg
module lfpd_regs
   import lfpd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_GAIN_P:         cfg_in.gain_p         = csr_data[GAIN_W-1:0];
            CSR_GAIN_I:         cfg_in.gain_i         = csr_data[GAIN_W-1:0];
            CSR_GAIN_D:         cfg_in.gain_d         = csr_data[GAIN_W-1:0];
            CSR_RIGHT_TRIM:     cfg_in.right_trim     = csr_data[CFG_W-1:0];
            CSR_DEAD_BAND:      cfg_in.dead_band      = csr_data[CFG_W-1:0];
            CSR_BASE_SPEED:     cfg_in.base_speed     = csr_data[CFG_W-1:0];
            CSR_PWM_LIMIT:      cfg_in.pwm_limit      = csr_data[CFG_W-1:0];
            CSR_INTEGRAL_LIMIT: cfg_in.integral_limit = csr_data[CFG_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p         <= GAIN_P_RST;
         cfg_ff.gain_i         <= GAIN_I_RST;
         cfg_ff.gain_d         <= GAIN_D_RST;
         cfg_ff.right_trim     <= RIGHT_TRIM_RST;
         cfg_ff.dead_band      <= DEAD_BAND_RST;
         cfg_ff.base_speed     <= BASE_SPEED_RST;
         cfg_ff.pwm_limit      <= PWM_LIMIT_RST;
         cfg_ff.integral_limit <= INTEGRAL_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[hw/rtl/lfpd_ctrl.sv]
// lfpd_ctrl: sequencer for one control tick, drives datapath commands and
// owns the handshake flags; depends on lfpd_pkg
module lfpd_ctrl
   import lfpd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output dp_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_P,
      ST_MUL_I,
      ST_MUL_D,
      ST_ACC,
      ST_DIV,
      ST_LR,
      ST_TRIM,
      ST_TDIV,
      ST_PACK
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd         = '0;
      cmd.mul_sel = MSEL_P;
      case (state_ff)
         ST_IDLE:  cmd.capture = req_valid;
         ST_MUL_P: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MSEL_P;
            cmd.acc_clr = 1'b1;
         end
         ST_MUL_I: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MSEL_I;
            cmd.acc_add = 1'b1;
         end
         ST_MUL_D: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MSEL_D;
            cmd.acc_add = 1'b1;
         end
         ST_ACC:   cmd.acc_add = 1'b1;
         ST_DIV:   cmd.div_en  = 1'b1;
         ST_LR:    cmd.lr_en   = 1'b1;
         ST_TRIM: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MSEL_T;
         end
         ST_TDIV:  cmd.tdiv_en = 1'b1;
         ST_PACK:  cmd.pack_en = out_free;
         default:  cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // in the final step a taken result is replaced by the new one below
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_PACK)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE:  if (req_valid) state_ff <= ST_MUL_P;
            ST_MUL_P: state_ff <= ST_MUL_I;
            ST_MUL_I: state_ff <= ST_MUL_D;
            ST_MUL_D: state_ff <= ST_ACC;
            ST_ACC:   state_ff <= ST_DIV;
            ST_DIV:   state_ff <= ST_LR;
            ST_LR:    state_ff <= ST_TRIM;
            ST_TRIM:  state_ff <= ST_TDIV;
            ST_TDIV:  state_ff <= ST_PACK;
            ST_PACK: begin
               // hold here while the previous result still waits
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default:  state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

[hw/rtl/lfpd_dpath.sv]
// lfpd_dpath: error extraction, shared multiplier with accumulator, scaling,
// trim and command packing, plus the result registers; depends on lfpd_pkg
module lfpd_dpath
   import lfpd_pkg::*;
#(
   parameter int SENSOR_COUNT = SENSOR_COUNT_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  dp_cmd_type               cmd,
   input  cfg_type                  cfg,
   input  logic [SENSOR_IN_W-1:0]   req_sensor_bits,
   output logic [PWM_W-1:0]         rsp_pwm_word,
   output logic signed [LERR_W-1:0] rsp_line_error,
   output logic                     rsp_line_seen
);

   localparam int IDX_W   = $clog2(SENSOR_COUNT);
   localparam int ERR_W   = IDX_W + 1;
   localparam int DERIV_W = ERR_W + 1;

   logic [SENSOR_COUNT-1:0] hit;
   logic [IDX_W-1:0]        first_idx;
   logic [IDX_W-1:0]        last_idx;
   logic                    seen;

   logic signed [ERR_W-1:0]   err_in;
   logic signed [ERR_W-1:0]   err_ff;
   logic signed [ERR_W-1:0]   last_ff;
   logic signed [DERIV_W-1:0] deriv_in;
   logic signed [DERIV_W-1:0] deriv_ff;
   logic signed [SUM_W:0]     sum_raw;
   logic signed [SUM_W:0]     sum_lim;
   logic signed [SUM_W:0]     sum_clamped;
   logic signed [SUM_W-1:0]   sum_ff;
   logic                      seen_ff;

   logic signed [OPA_W-1:0]  opa;
   logic signed [OPB_W-1:0]  opb;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_rnd;
   logic signed [CORR_W-1:0] corr_ff;
   logic signed [CMD_W-1:0]  left_in;
   logic signed [CMD_W-1:0]  left_ff;
   logic signed [OPB_W-1:0]  right_in;
   logic signed [OPB_W-1:0]  right_ff;
   logic signed [PROD_W-1:0] prod_rnd;
   logic signed [CMD_W-1:0]  trimmed_ff;

   logic [PWM_W-1:0]           pwm_ff;
   logic signed [LERR_W-1:0]   lerr_ff;
   logic                       lseen_ff;
   logic [ERR_W+LERR_W-1:0]    err_ext;

   // sensors above the input width always read as clear
   for (genvar g = 0; g < SENSOR_COUNT; g++) begin : g_hit
      if (g < SENSOR_IN_W) begin : g_real
         assign hit[g] = req_sensor_bits[g];
      end else begin : g_none
         assign hit[g] = 1'b0;
      end
   end

   always_comb begin
      first_idx = '0;
      last_idx  = '0;
      for (int i = SENSOR_COUNT - 1; i >= 0; i--) begin
         if (hit[i]) first_idx = IDX_W'(i);
      end
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         if (hit[i]) last_idx = IDX_W'(i);
      end
      seen = |hit;
   end

   always_comb begin
      err_in = seen ? ERR_W'(int'(first_idx) + int'(last_idx) - (SENSOR_COUNT - 1))
                    : last_ff;
      deriv_in = $signed({err_in[ERR_W-1], err_in}) - $signed({last_ff[ERR_W-1], last_ff});
      sum_raw  = $signed({sum_ff[SUM_W-1], sum_ff})
               + $signed({{(SUM_W+1-ERR_W){err_in[ERR_W-1]}}, err_in});
      sum_lim  = $signed({{(SUM_W+1-CFG_W){1'b0}}, cfg.integral_limit});
      if (sum_raw > sum_lim) begin
         sum_clamped = sum_lim;
      end else if (sum_raw < -sum_lim) begin
         sum_clamped = -sum_lim;
      end else begin
         sum_clamped = sum_raw;
      end
   end

   // operand select for the shared multiplier
   always_comb begin
      case (cmd.mul_sel)
         MSEL_P: begin
            opa = $signed({1'b0, cfg.gain_p});
            opb = $signed({{(OPB_W-ERR_W){err_ff[ERR_W-1]}}, err_ff});
         end
         MSEL_I: begin
            opa = $signed({1'b0, cfg.gain_i});
            opb = $signed({{(OPB_W-SUM_W){sum_ff[SUM_W-1]}}, sum_ff});
         end
         MSEL_D: begin
            opa = $signed({1'b0, cfg.gain_d});
            opb = $signed({{(OPB_W-DERIV_W){deriv_ff[DERIV_W-1]}}, deriv_ff});
         end
         MSEL_T: begin
            opa = $signed({{(OPA_W-CFG_W){1'b0}}, cfg.right_trim});
            opb = right_ff;
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
      prod_in = opa * opb;
   end

   always_comb begin
      acc_in = acc_ff;
      if (cmd.acc_clr) begin
         acc_in = '0;
      end else if (cmd.acc_add) begin
         acc_in = acc_ff + prod_ff[ACC_W-1:0];
      end
      // bias negative values so the shift truncates toward zero
      acc_rnd  = acc_ff + $signed({{(ACC_W-P_FRAC){1'b0}}, {P_FRAC{acc_ff[ACC_W-1]}}});
      prod_rnd = prod_ff + $signed({{(PROD_W-T_FRAC){1'b0}}, {T_FRAC{prod_ff[PROD_W-1]}}});
      left_in  = $signed({{(CMD_W-CFG_W){1'b0}}, cfg.base_speed})
               + $signed({{(CMD_W-CORR_W){corr_ff[CORR_W-1]}}, corr_ff});
      right_in = $signed({{(OPB_W-CFG_W){1'b0}}, cfg.base_speed})
               - $signed({{(OPB_W-CORR_W){corr_ff[CORR_W-1]}}, corr_ff});
      err_ext  = {{LERR_W{err_ff[ERR_W-1]}}, err_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= '0;
         sum_ff  <= '0;
      end else if (cmd.capture) begin
         last_ff <= err_in;
         sum_ff  <= sum_clamped[SUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         err_ff   <= err_in;
         deriv_ff <= deriv_in;
         seen_ff  <= seen;
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      acc_ff <= acc_in;
      if (cmd.div_en) begin
         corr_ff <= acc_rnd[ACC_W-1:P_FRAC];
      end
      if (cmd.lr_en) begin
         left_ff  <= left_in;
         right_ff <= right_in;
      end
      if (cmd.tdiv_en) begin
         trimmed_ff <= prod_rnd[T_FRAC+CMD_W-1:T_FRAC];
      end
      if (cmd.pack_en) begin
         pwm_ff   <= {pack_wheel(left_ff, cfg.dead_band, cfg.pwm_limit),
                      pack_wheel(trimmed_ff, cfg.dead_band, cfg.pwm_limit)};
         lerr_ff  <= $signed(err_ext[LERR_W-1:0]);
         lseen_ff <= seen_ff;
      end
   end

   assign rsp_pwm_word   = pwm_ff;
   assign rsp_line_error = lerr_ff;
   assign rsp_line_seen  = lseen_ff;

endmodule

[hw/rtl/line_follower_pid_motor_drive.sv]
// line_follower_pid_motor_drive: top level, pid line follower with
// differential drive command packing; depends on lfpd_pkg, lfpd_regs,
// lfpd_ctrl and lfpd_dpath
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  req_sensor_bits
//   rsp      out        rsp_valid/rsp_ready  rsp_pwm_word, rsp_line_error, rsp_line_seen
//   csr      in         csr_valid/csr_ready  csr_index, csr_data
//
// rsp_valid rises once the sequencer has run its multiply, accumulate, scale, trim
// and pack steps after the req transfer, and no new req is taken before that: a single
// shared multiplier is used four times in sequence (three gains, then the right trim)
// the next transfer is accepted right after the result is loaded, while that
// result may still wait in its output register
// a stalled result holds the sequencer in its final step until it is taken
// synchronous reset restores register defaults and clears the error history
module line_follower_pid_motor_drive
   import lfpd_pkg::*;
#(
   parameter int SENSOR_COUNT = SENSOR_COUNT_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [SENSOR_IN_W-1:0]   req_sensor_bits,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [PWM_W-1:0]         rsp_pwm_word,
   output logic signed [LERR_W-1:0] rsp_line_error,
   output logic                     rsp_line_seen,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_data
);

   cfg_type    cfg;
   dp_cmd_type cmd;

   lfpd_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   lfpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   lfpd_dpath #(
      .SENSOR_COUNT (SENSOR_COUNT)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .cfg             (cfg),
      .req_sensor_bits (req_sensor_bits),
      .rsp_pwm_word    (rsp_pwm_word),
      .rsp_line_error  (rsp_line_error),
      .rsp_line_seen   (rsp_line_seen)
   );

endmodule
